### rtl/ggs_pkg.sv
// ----------------------------------------------------------------------------
// ggs_pkg
// Opcodes, register indexes and the elaboration-time helpers that build the
// Gaussian weight table.
// ----------------------------------------------------------------------------
package ggs_pkg;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_SPREAD = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    localparam logic [1:0] REG_GRID_SCALE  = 2'd0;
    localparam logic [1:0] REG_GAUSS_COEF  = 2'd1;
    localparam logic [1:0] REG_SPREAD_HALF = 2'd2;
    localparam logic [1:0] REG_UNIT_WEIGHT = 2'd3;

    localparam int ACC_W = 40;

    // (a*b) >> 62 for a, b below 2^63
    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // exp(-1/16) in Q62 by its series
    function automatic logic [63:0] calc_exp_step();
        logic [63:0] term;
        logic [63:0] e;
        term = 64'd1 << 62;
        e = term;
        for (int k = 1; k < 24; k++)
        begin
            term = term / 64'(16 * k);
            if ((k & 1) != 0)
                e = e - term;
            else
                e = e + term;
        end
        return e;
    endfunction

    localparam logic [63:0] EXP_STEP_Q62 = calc_exp_step();

endpackage

### rtl/gaussian_grid_spreader.sv
// ----------------------------------------------------------------------------
// gaussian_grid_spreader
// Spreads samples onto a periodic grid of saturating accumulators with a
// Gaussian kernel; clears and reads the grid on request.
// ----------------------------------------------------------------------------
// Each request returns exactly one result. The grid lives in a simple dual-port
// synchronous RAM that is updated by read-modify-write through a weight
// pipeline. A spread runs from acceptance to result through the accepting
// cycle, the position multiply, the start-index setup, the modulo reduction of
// the start index by reciprocal multiplication, one grid point per cycle
// through the RAM update path, the pipe drain and the load of the output
// register. A read registers the RAM word at acceptance, captures it in
// ST_READ and then loads the output register; an unknown opcode goes straight
// to ST_DONE. A clear sweeps the RAM one entry per cycle; the same sweep runs
// after reset, during which no request is taken.
// A result waits in an output register, so a new request is taken while it is
// stalled.
module gaussian_grid_spreader
    import ggs_pkg::*;
#(
    parameter int GRID_DEPTH     = 1024,
    parameter int MAX_HALF_WIDTH = 12,
    parameter int EXP_ENTRIES    = 1024
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         opcode,
    input  logic [31:0]        sample_time,
    input  logic signed [15:0] sample_value,
    input  logic [9:0]         entry_index,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         done_opcode,
    output logic signed [39:0] entry_value,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int AW   = $clog2(GRID_DEPTH);
    localparam int EW   = $clog2(EXP_ENTRIES);
    localparam int AD_W = $clog2(MAX_HALF_WIDTH * 65536 + 1);
    localparam int DD_W = AD_W + 1;
    localparam int SQ_W = 2 * AD_W;
    localparam int PW   = SQ_W + 17;
    localparam int IX_W = PW - 36;
    localparam int HW   = $clog2(MAX_HALF_WIDTH + 1);
    localparam int CW   = HW + 1;
    localparam int OFFS = GRID_DEPTH * ((MAX_HALF_WIDTH + GRID_DEPTH - 1) / GRID_DEPTH);
    localparam int VW   = $clog2(65536 + OFFS + 1);
    // floor(x / GRID_DEPTH) = (x * RECIP) >> QS, exact for any x below 2^VW
    localparam int QS   = VW + AW;
    localparam int MW   = VW + 2;
    localparam int QP_W = VW + MW;
    localparam longint RECIP_L = ((longint'(1) << QS) + longint'(GRID_DEPTH) - 1)
                                 / longint'(GRID_DEPTH);
    localparam logic [MW-1:0] RECIP = MW'(RECIP_L);

    localparam logic [3:0] ST_CLEAR  = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_POS    = 4'd2;
    localparam logic [3:0] ST_PREP   = 4'd3;
    localparam logic [3:0] ST_MOD    = 4'd4;
    localparam logic [3:0] ST_SPREAD = 4'd5;
    localparam logic [3:0] ST_DRAIN  = 4'd6;
    localparam logic [3:0] ST_READ   = 4'd7;
    localparam logic [3:0] ST_DONE   = 4'd8;
    localparam logic [3:0] ST_WRAP   = 4'd9;

    typedef logic [14:0] exp_rom_t [EXP_ENTRIES];

    function automatic exp_rom_t build_exp_rom();
        exp_rom_t    tab;
        logic [63:0] w;
        logic [63:0] q40;
        w = 64'd1 << 62;
        for (int i = 0; i < EXP_ENTRIES; i++)
        begin
            q40 = w >> 22;
            tab[i] = 15'((64'd32767 * q40 + (64'd1 << 39)) >> 40);
            w = mul_q62(w, EXP_STEP_Q62);
        end
        return tab;
    endfunction

    localparam exp_rom_t EXP_ROM = build_exp_rom();

    // configuration
    logic [23:0] grid_scale_reg;
    logic [15:0] gauss_coef_reg;
    logic [3:0]  spread_half_reg;
    logic        unit_weight_reg;

    logic        cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_scale_reg  <= 24'd1048576;
            gauss_coef_reg  <= 16'd256;
            spread_half_reg <= 4'd6;
            unit_weight_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_GRID_SCALE:  grid_scale_reg  <= pwdata[23:0];
                REG_GAUSS_COEF:  gauss_coef_reg  <= pwdata[15:0];
                REG_SPREAD_HALF: spread_half_reg <= pwdata[3:0];
                REG_UNIT_WEIGHT: unit_weight_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_GRID_SCALE:  prdata = {8'd0, grid_scale_reg};
            REG_GAUSS_COEF:  prdata = {16'd0, gauss_coef_reg};
            REG_SPREAD_HALF: prdata = {28'd0, spread_half_reg};
            REG_UNIT_WEIGHT: prdata = {31'd0, unit_weight_reg};
            default:         prdata = 32'd0;
        endcase
    end

    // control and request registers
    logic [3:0]         state_reg, state_next;
    logic [1:0]         opc_reg;
    logic [31:0]        time_reg;
    logic signed [15:0] val_reg;
    logic               rd_ok_reg;
    logic [55:0]        pos_prod_reg;
    logic [VW-1:0]      modv_reg;
    logic [VW-1:0]      q_reg;
    logic signed [DD_W-1:0] d_reg;
    logic [AW-1:0]      g_reg;
    logic [CW-1:0]      cnt_reg;
    logic [CW-1:0]      npts_reg;
    logic [AW-1:0]      clr_reg;
    logic               pend_reg;
    logic signed [39:0] res_reg;
    logic               out_valid_reg;
    logic [1:0]         out_opc_reg;
    logic signed [39:0] out_val_reg;

    // spread pipeline
    logic               s1_v, s2_v, s3_v, s4_v;
    logic [SQ_W-1:0]    s1_sq;
    logic [PW-1:0]      s2_prod;
    logic               s3_zero;
    logic [14:0]        rom_q;
    logic [15:0]        s4_w;
    logic signed [31:0] s4_mul;
    logic [AW-1:0]      s1_g, s2_g, s3_g, s4_g;

    // grid RAM
    logic signed [39:0] grid_mem [GRID_DEPTH];
    logic signed [39:0] rdata_reg;
    logic [AW-1:0]      rd_addr;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic signed [39:0] wr_data;

    logic               accept;
    logic               issue;
    logic               load_out;
    logic [CW-1:0]      heff;
    logic [31:0]        pos;
    logic [16:0]        m1;
    logic [15:0]        u;
    logic [QP_W-1:0]    q_prod;
    logic [AD_W-1:0]    ad;
    logic [PW-1:0]      idx_sum;
    logic [IX_W-1:0]    idx;
    logic [31:0]        entry_wide;
    logic signed [16:0] add_val;
    logic signed [40:0] sum;
    logic signed [39:0] sat_sum;

    assign accept   = in_valid && (state_reg == ST_IDLE);
    assign in_stall = (state_reg != ST_IDLE);
    assign issue    = (state_reg == ST_SPREAD);
    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    assign out_valid   = out_valid_reg;
    assign done_opcode = out_opc_reg;
    assign entry_value = out_val_reg;

    always_comb
    begin
        if (spread_half_reg == 4'd0)
            heff = CW'(1);
        else if (32'(spread_half_reg) > 32'(MAX_HALF_WIDTH))
            heff = CW'(MAX_HALF_WIDTH);
        else
            heff = CW'(spread_half_reg);
    end

    assign pos = pos_prod_reg[55:24];
    assign m1  = 17'(({1'b0, pos} + 33'h0FFFF) >> 16);
    assign u   = 16'd0 - pos[15:0];

    assign q_prod = QP_W'(modv_reg) * QP_W'(RECIP);

    assign ad      = AD_W'((d_reg < 0) ? -d_reg : d_reg);
    assign idx_sum = s2_prod + (PW'(1) << 35);
    assign idx     = idx_sum[PW-1:36];

    assign entry_wide = 32'(entry_index);

    // state machine
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == AW'(GRID_DEPTH - 1))
                    state_next = pend_reg ? ST_DONE : ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (opcode)
                        OP_CLEAR:  state_next = ST_CLEAR;
                        OP_SPREAD: state_next = ST_POS;
                        OP_READ:   state_next = ST_READ;
                        default:   state_next = ST_DONE;
                    endcase
                end
            end
            ST_POS:    state_next = ST_PREP;
            ST_PREP:   state_next = ST_MOD;
            ST_MOD:    state_next = ST_WRAP;
            ST_WRAP:   state_next = ST_SPREAD;
            ST_SPREAD:
            begin
                if (cnt_reg == npts_reg - CW'(1))
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (!(s1_v || s2_v || s3_v || s4_v))
                    state_next = ST_DONE;
            end
            ST_READ:   state_next = ST_DONE;
            ST_DONE:
            begin
                if (load_out)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            s1_v          <= 1'b0;
            s2_v          <= 1'b0;
            s3_v          <= 1'b0;
            s4_v          <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            s1_v <= issue;
            s2_v <= s1_v;
            s3_v <= s2_v;
            s4_v <= s3_v;
            if (state_reg == ST_CLEAR)
                clr_reg <= (clr_reg == AW'(GRID_DEPTH - 1)) ? '0 : clr_reg + AW'(1);
            if (accept)
                pend_reg <= 1'b1;
            else if (load_out)
                pend_reg <= 1'b0;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            opc_reg   <= opcode;
            time_reg  <= sample_time;
            val_reg   <= sample_value;
            rd_ok_reg <= (entry_wide < 32'(GRID_DEPTH));
            res_reg   <= '0;
        end
        if (state_reg == ST_POS)
            pos_prod_reg <= 56'(time_reg) * 56'(grid_scale_reg);
        if (state_reg == ST_PREP)
        begin
            modv_reg <= VW'(m1) + VW'(OFFS) - VW'(heff - CW'(1));
            d_reg    <= DD_W'(u) - (DD_W'(heff - CW'(1)) <<< 16);
            cnt_reg  <= '0;
            npts_reg <= heff << 1;
        end
        if (state_reg == ST_MOD)
            q_reg <= VW'(q_prod >> QS);
        if (state_reg == ST_WRAP)
            g_reg <= AW'(modv_reg - VW'(32'(q_reg) * 32'(GRID_DEPTH)));
        if (issue)
        begin
            d_reg   <= d_reg + DD_W'(65536);
            g_reg   <= (g_reg == AW'(GRID_DEPTH - 1)) ? '0 : g_reg + AW'(1);
            cnt_reg <= cnt_reg + CW'(1);
        end
        if (state_reg == ST_READ)
            res_reg <= rd_ok_reg ? rdata_reg : '0;
        if (load_out)
        begin
            out_opc_reg <= opc_reg;
            out_val_reg <= res_reg;
        end

        // weight pipeline
        s1_sq   <= SQ_W'(ad) * SQ_W'(ad);
        s1_g    <= g_reg;
        s2_prod <= PW'(gauss_coef_reg) * PW'(s1_sq);
        s2_g    <= s1_g;
        s3_zero <= (idx >= IX_W'(EXP_ENTRIES));
        rom_q   <= EXP_ROM[idx[EW-1:0]];
        s3_g    <= s2_g;
        s4_w    <= s3_zero ? 16'd0 : {1'b0, rom_q};
        s4_mul  <= val_reg * signed'({1'b0, s3_zero ? 15'd0 : rom_q});
        s4_g    <= s3_g;
    end

    // value mode rounds half up: floor((p + 2^14) / 2^15)
    assign add_val = unit_weight_reg ? signed'({1'b0, s4_w})
                                     : 17'((s4_mul + 32'sd16384) >>> 15);
    assign sum     = 41'(rdata_reg) + 41'(add_val);
    assign sat_sum = (sum > 41'sh7F_FFFF_FFFF) ? 40'sh7F_FFFF_FFFF :
                     (sum < -41'sh80_0000_0000) ? -40'sh80_0000_0000 : sum[39:0];

    assign rd_addr = (state_reg == ST_IDLE) ? entry_wide[AW-1:0] : s3_g;

    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_reg;
            wr_data = '0;
        end
        else
        begin
            wr_en   = s4_v;
            wr_addr = s4_g;
            wr_data = sat_sum;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            grid_mem[wr_addr] <= wr_data;
        rdata_reg <= grid_mem[rd_addr];
    end

endmodule
